// File: sv/dfe_pkg.sv
// shared types and constants for the delimited field extractor
`timescale 1ns / 1ps
`default_nettype none

package dfe_pkg;

    localparam int unsigned PATTERN_BYTES = 8;
    localparam int unsigned BUFFER_BYTES  = 65536;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PAT_W   = PATTERN_BYTES * BYTE_W;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned CFG_W   = 64;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FPTR_W  = $clog2(FIFO_DEPTH);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PREFIX_BYTES = 3'd0;
    localparam logic [CIDX_W-1:0] REG_PREFIX_COUNT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SUFFIX_BYTES = 3'd2;
    localparam logic [CIDX_W-1:0] REG_SUFFIX_COUNT = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MAX_LENGTH   = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } word_t;

    typedef struct packed {
        logic [PAT_W-1:0] prefix_bytes;
        logic [CNT_W-1:0] prefix_count;
        logic [PAT_W-1:0] suffix_bytes;
        logic [CNT_W-1:0] suffix_count;
        logic [LEN_W-1:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start_offset;
        logic [LEN_W-1:0] field_length;
    } result_t;

endpackage

`default_nettype wire

// File: sv/dfe_fifo.sv
// input word queue between the accepting front and the scanner
`timescale 1ns / 1ps
`default_nettype none

module dfe_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire dfe_pkg::word_t push_word,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output dfe_pkg::word_t     pop_word
);

    dfe_pkg::word_t mem_reg [dfe_pkg::FIFO_DEPTH];
    logic [dfe_pkg::FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dfe_pkg::FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dfe_pkg::FPTR_W:0]   count_reg, count_next;
    logic push, pop;

    assign push_ready = (count_reg != (dfe_pkg::FPTR_W+1)'(dfe_pkg::FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// File: sv/dfe_scan.sv
// prefix and suffix scanner with registered result output
`timescale 1ns / 1ps
`default_nettype none

module dfe_scan (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire dfe_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dfe_pkg::word_t in_word,
    output logic                out_valid,
    input  wire logic           out_ready,
    output dfe_pkg::result_t    out_result
);

    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_FIELD  = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [dfe_pkg::CNT_W-1:0] PAT_MAX = dfe_pkg::CNT_W'(dfe_pkg::PATTERN_BYTES);
    localparam logic [dfe_pkg::POS_W-1:0] POS_END = dfe_pkg::POS_W'(dfe_pkg::BUFFER_BYTES);

    logic [1:0]                 phase_reg, phase_next;
    logic [dfe_pkg::CNT_W-1:0]  match_reg, match_next;
    logic [dfe_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [dfe_pkg::POS_W-1:0]  start_reg, start_next;
    logic [dfe_pkg::LEN_W-1:0]  count_reg, count_next;
    logic                       out_valid_reg;
    dfe_pkg::result_t           result_reg, result_next;

    logic [dfe_pkg::CNT_W-1:0]  pc, sc;
    logic [dfe_pkg::BYTE_W-1:0] pbyte, sbyte;
    logic                       advance, emit, ok, end_buf;

    assign pc = (cfg.prefix_count > PAT_MAX) ? PAT_MAX : cfg.prefix_count;
    assign sc = (cfg.suffix_count > PAT_MAX) ? PAT_MAX : cfg.suffix_count;

    assign advance   = in_valid && (!out_valid_reg || out_ready);
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_result = result_reg;

    always_comb begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        emit        = 1'b0;
        ok          = 1'b0;
        end_buf     = 1'b0;
        pbyte       = '0;
        sbyte       = '0;

        if (phase_reg != PH_DONE && pos_reg >= POS_END) begin
            end_buf = 1'b1;
        end else begin
            // prefix already complete, field starts at this byte
            if (phase_next == PH_SEARCH && match_next >= pc) begin
                phase_next = PH_FIELD;
                start_next = pos_reg;
                match_next = '0;
                count_next = '0;
            end
            if (phase_next == PH_SEARCH) begin
                pbyte = cfg.prefix_bytes[{match_next[2:0], 3'b000} +: dfe_pkg::BYTE_W];
                if (in_word.data_byte == pbyte) begin
                    match_next = match_next + 1'b1;
                end else begin
                    match_next = '0;
                end
                if (match_next >= pc) begin
                    phase_next = PH_FIELD;
                    start_next = pos_reg + 1'b1;
                    match_next = '0;
                    count_next = '0;
                end
            end else if (phase_next == PH_FIELD) begin
                sbyte = cfg.suffix_bytes[{match_next[2:0], 3'b000} +: dfe_pkg::BYTE_W];
                if (sc != '0 && match_next >= sc) begin
                    emit = 1'b1;
                    ok   = 1'b1;
                end else if (sc != '0 && in_word.data_byte == sbyte) begin
                    match_next = match_next + 1'b1;
                    if (match_next >= sc) begin
                        emit = 1'b1;
                        ok   = 1'b1;
                    end
                end else if (count_next >= cfg.max_length) begin
                    emit = 1'b1;
                    ok   = (sc == '0);
                end else begin
                    count_next = count_next + 1'b1;
                end
            end
            if (pos_reg < POS_END) begin
                pos_next = pos_reg + 1'b1;
            end
            if (in_word.last && !emit) begin
                end_buf = 1'b1;
            end
        end

        // buffer ended or overran before the outcome was settled
        if (end_buf) begin
            if (phase_next == PH_SEARCH) begin
                emit = 1'b1;
                ok   = 1'b0;
            end else if (phase_next == PH_FIELD) begin
                emit = 1'b1;
                ok   = (sc == '0) || (match_next >= sc);
            end
        end

        result_next.found        = ok;
        result_next.start_offset = ok ? start_next : '0;
        result_next.field_length = ok ? count_next : '0;

        if (emit) begin
            phase_next = PH_DONE;
        end
        if (in_word.last) begin
            phase_next = PH_SEARCH;
            match_next = '0;
            pos_next   = '0;
            start_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEARCH;
            match_reg     <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                match_reg <= match_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                count_reg <= count_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/delimited_field_extractor_core.sv
// an accepted word is queued and scanned at the queue head; a settled result is registered
// in the scanner result register that drives m_valid
// throughput: one word per cycle, set by the combinational compare and count step, while no
// result waits on m_ready; a four-word queue decouples input acceptance from such stalls
// reset: synchronous active-low aresetn clears the queue, scan state and result valid;
// configuration resets to empty prefix and suffix and max_length 65535
`timescale 1ns / 1ps
`default_nettype none

module delimited_field_extractor_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [dfe_pkg::BYTE_W-1:0]   s_data_byte,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_found,
    output logic [dfe_pkg::POS_W-1:0]         m_start_offset,
    output logic [dfe_pkg::LEN_W-1:0]         m_field_length,
    input  wire logic                         cfg_wr_en,
    input  wire logic [dfe_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [dfe_pkg::CFG_W-1:0]    cfg_wdata
);

    dfe_pkg::cfg_t    cfg_reg;
    dfe_pkg::word_t   in_word, q_word;
    dfe_pkg::result_t result;
    logic             q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prefix_bytes <= '0;
            cfg_reg.prefix_count <= '0;
            cfg_reg.suffix_bytes <= '0;
            cfg_reg.suffix_count <= '0;
            cfg_reg.max_length   <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dfe_pkg::REG_PREFIX_BYTES: begin
                    cfg_reg.prefix_bytes <= cfg_wdata[dfe_pkg::PAT_W-1:0];
                end
                dfe_pkg::REG_PREFIX_COUNT: begin
                    cfg_reg.prefix_count <= cfg_wdata[dfe_pkg::CNT_W-1:0];
                end
                dfe_pkg::REG_SUFFIX_BYTES: begin
                    cfg_reg.suffix_bytes <= cfg_wdata[dfe_pkg::PAT_W-1:0];
                end
                dfe_pkg::REG_SUFFIX_COUNT: begin
                    cfg_reg.suffix_count <= cfg_wdata[dfe_pkg::CNT_W-1:0];
                end
                dfe_pkg::REG_MAX_LENGTH: begin
                    cfg_reg.max_length <= cfg_wdata[dfe_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign in_word.data_byte = s_data_byte;
    assign in_word.last      = s_last;

    dfe_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_word  (in_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    dfe_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_word    (q_word),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_found        = result.found;
    assign m_start_offset = result.start_offset;
    assign m_field_length = result.field_length;

endmodule

`default_nettype wire
